// ----- design/cmaa_pkg.sv -----
package cmaa_pkg;

    // Sizes of the fields and of the window
    localparam int MAX_HALF_WIDTH = 15;
    localparam int COUNT_WIDTH    = 16;
    localparam int SAMPLE_W       = 10;
    localparam int HW_W           = 4;
    localparam int LEVEL_W        = 10;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 10;
    localparam int HIST_DEPTH     = 2 * MAX_HALF_WIDTH + 1;
    localparam int PTR_W          = $clog2(HIST_DEPTH);
    localparam int CNT_W          = $clog2(HIST_DEPTH + 1);
    localparam int SUM_W          = $clog2(HIST_DEPTH * ((1 << SAMPLE_W) - 1) + 1);
    localparam int PROD_W         = LEVEL_W + CNT_W;
    localparam int CMP_W          = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int STEP_W         = $clog2(SUM_W + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ALERT_LEVEL = CFG_IDX_W'(1);

    // Register reset values
    localparam logic [HW_W-1:0]    HALF_WIDTH_RST  = HW_W'(1);
    localparam logic [LEVEL_W-1:0] ALERT_LEVEL_RST = LEVEL_W'(500);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;     // take the input transfer
        logic start_res;  // set up the window of the next result
        logic rd_issue;   // read one history entry
        logic accum;      // add the read entry to the sum
        logic div_start;  // launch the division and the alert compare
        logic load_out;   // move the result into the output register
    } cmaa_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic no_result;  // item leaves its window incomplete
        logic last_elem;  // current entry is the oldest of the window
        logic div_busy;   // divider still running
        logic out_free;   // output register can take a result
        logic final_res;  // current result is the last one of the item
    } cmaa_stat_t;

endpackage

// ----- design/cmaa_div.sv -----
module cmaa_div
    import cmaa_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             busy,
    output logic [SUM_W-1:0] quotient
);

    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic [CNT_W:0]    rem_shift;
    logic [CNT_W:0]    rem_diff;
    logic              fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        rem_shift = {rem_reg, quo_reg[SUM_W-1]};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        fits      = (rem_shift >= {1'b0, dvs_reg});
        quo_next  = {quo_reg[SUM_W-2:0], fits};
        rem_next  = fits ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
        step_next = step_reg - STEP_W'(1);
        busy_next = (step_reg != STEP_W'(1));
    end

    // Hold the busy flag and the step count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(SUM_W);
        end else if (busy_reg) begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Advance the partial remainder and quotient
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ----- design/cmaa_datapath.sv -----
module cmaa_datapath
    import cmaa_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [SAMPLE_W-1:0]    s_sample,
    input  logic                   s_last_sample,
    input  cmaa_cmd_t              cmd,
    output cmaa_stat_t             stat,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SAMPLE_W-1:0]    m_average,
    output logic                   m_above_alert,
    output logic                   m_end_of_run,
    output logic                   m_end_of_set,
    output logic [COUNT_WIDTH-1:0] m_alert_total
);

    logic [SAMPLE_W-1:0]    hist_mem [HIST_DEPTH];
    logic [SAMPLE_W-1:0]    rd_data_reg;

    logic [HW_W-1:0]        half_width_reg;
    logic [LEVEL_W-1:0]     alert_level_reg;
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [COUNT_WIDTH-1:0] seen_reg, seen_next;
    logic [COUNT_WIDTH-1:0] alert_cnt_reg, alert_cnt_next;
    logic                   m_valid_reg;

    logic [PTR_W-1:0]       newest_reg;
    logic [COUNT_WIDTH-1:0] idx_reg;
    logic                   last_reg;
    logic [HW_W-1:0]        h_reg;
    logic [HW_W-1:0]        k_reg, k_next;
    logic [PTR_W-1:0]       addr_reg, addr_next;
    logic [PTR_W-1:0]       d_reg;
    logic [PTR_W-1:0]       dmax_reg, dmax_next;
    logic [SUM_W-1:0]       sum_reg;
    logic                   alert_reg;

    logic [PTR_W-1:0]       kh;
    logic [CNT_W-1:0]       win_cnt;
    logic [PROD_W-1:0]      level_prod;
    logic                   div_busy;
    logic [SUM_W-1:0]       quotient;
    logic                   final_res;

    logic [SAMPLE_W-1:0]    avg_reg;
    logic                   above_reg;
    logic                   eor_reg;
    logic                   eos_reg;
    logic [COUNT_WIDTH-1:0] total_reg;

    cmaa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (win_cnt),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // Window bounds, counts and pointer steps
    always_comb begin
        wr_ptr_next = (wr_ptr_reg == PTR_W'(HIST_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        addr_next   = (addr_reg == '0) ? PTR_W'(HIST_DEPTH - 1) : addr_reg - PTR_W'(1);
        seen_next   = s_last_sample ? '0 :
                      ((seen_reg == '1) ? seen_reg : seen_reg + COUNT_WIDTH'(1));
        // results of a flush start at the oldest complete position
        if (s_last_sample && (seen_reg < COUNT_WIDTH'(half_width_reg)))
            k_next = seen_reg[HW_W-1:0];
        else
            k_next = half_width_reg;
        // window reaches k+h back from the newest sample, cut at the set start
        kh = PTR_W'(k_reg) + PTR_W'(h_reg);
        if (idx_reg < COUNT_WIDTH'(kh))
            dmax_next = idx_reg[PTR_W-1:0];
        else
            dmax_next = kh;
        win_cnt    = CNT_W'(dmax_reg) + CNT_W'(1);
        level_prod = PROD_W'(alert_level_reg) * PROD_W'(win_cnt);
        final_res  = !last_reg || (k_reg == '0);
        alert_cnt_next = (alert_reg && (alert_cnt_reg != '1)) ?
                         alert_cnt_reg + COUNT_WIDTH'(1) : alert_cnt_reg;
    end

    assign stat.no_result = !last_reg && (idx_reg < COUNT_WIDTH'(h_reg));
    assign stat.last_elem = (d_reg == dmax_reg);
    assign stat.div_busy  = div_busy;
    assign stat.out_free  = !m_valid_reg || m_ready;
    assign stat.final_res = final_res;

    // Hold configuration, set counters and the output valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg  <= HALF_WIDTH_RST;
            alert_level_reg <= ALERT_LEVEL_RST;
            wr_ptr_reg      <= '0;
            seen_reg        <= '0;
            alert_cnt_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_HALF_WIDTH:  half_width_reg  <= cfg_data[HW_W-1:0];
                    REG_ALERT_LEVEL: alert_level_reg <= cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.accept) begin
                wr_ptr_reg <= wr_ptr_next;
                seen_reg   <= seen_next;
            end
            if (cmd.load_out)
                alert_cnt_reg <= (final_res && last_reg) ? '0 : alert_cnt_next;
            if (cmd.load_out)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
        end
    end

    // Write the history ring and read one entry
    always_ff @(posedge aclk) begin
        if (cmd.accept)
            hist_mem[wr_ptr_reg] <= s_sample;
        if (cmd.rd_issue)
            rd_data_reg <= hist_mem[addr_reg];
    end

    // Item context, window walk, sum and result payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            newest_reg <= wr_ptr_reg;
            idx_reg    <= seen_reg;
            last_reg   <= s_last_sample;
            h_reg      <= half_width_reg;
            k_reg      <= k_next;
        end
        if (cmd.start_res) begin
            addr_reg <= newest_reg;
            d_reg    <= '0;
            dmax_reg <= dmax_next;
            sum_reg  <= '0;
        end
        if (cmd.accum) begin
            sum_reg  <= sum_reg + SUM_W'(rd_data_reg);
            d_reg    <= d_reg + PTR_W'(1);
            addr_reg <= addr_next;
        end
        if (cmd.div_start)
            alert_reg <= CMP_W'(sum_reg) > CMP_W'(level_prod);
        if (cmd.load_out) begin
            avg_reg   <= quotient[SAMPLE_W-1:0];
            above_reg <= alert_reg;
            eor_reg   <= final_res;
            eos_reg   <= final_res && last_reg;
            total_reg <= (final_res && last_reg) ? alert_cnt_next : '0;
            if (!final_res)
                k_reg <= k_reg - HW_W'(1);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_average     = avg_reg;
    assign m_above_alert = above_reg;
    assign m_end_of_run  = eor_reg;
    assign m_end_of_set  = eos_reg;
    assign m_alert_total = total_reg;

endmodule

// ----- design/cmaa_ctrl.sv -----
module cmaa_ctrl
    import cmaa_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  cmaa_stat_t stat,
    output cmaa_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_START,
        ST_READ,
        ST_ADD,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    // Decode commands and the next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_valid;
                if (s_valid)
                    state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = stat.no_result ? ST_IDLE : ST_START;
            end
            ST_START: begin
                cmd.start_res = 1'b1;
                state_next    = ST_READ;
            end
            ST_READ: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_ADD;
            end
            ST_ADD: begin
                cmd.accum  = 1'b1;
                state_next = stat.last_elem ? ST_DIV_GO : ST_READ;
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!stat.div_busy)
                    state_next = ST_OUT;
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = stat.final_res ? ST_IDLE : ST_START;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

// ----- design/centered_moving_average_alert.sv -----
// Each result sums its window from the history ring, one entry read and then added at a
// time, then runs a restoring divider at one quotient bit per cycle; each item also
// takes a transfer and one window check. An item causes zero, one, or up to 16
// results. A new item is taken once the last result of the previous one is in the
// output register. Synchronous active-low reset clears the controller, counters and
// configuration registers to their defaults; the history ring holds no reset value.
module centered_moving_average_alert
    import cmaa_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_W-1:0]    s_sample,
    input  logic                   s_last_sample,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SAMPLE_W-1:0]    m_average,
    output logic                   m_above_alert,
    output logic                   m_end_of_run,
    output logic                   m_end_of_set,
    output logic [COUNT_WIDTH-1:0] m_alert_total
);

    cmaa_cmd_t  cmd;
    cmaa_stat_t stat;

    cmaa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cmaa_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_sample      (s_sample),
        .s_last_sample (s_last_sample),
        .cmd           (cmd),
        .stat          (stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_average     (m_average),
        .m_above_alert (m_above_alert),
        .m_end_of_run  (m_end_of_run),
        .m_end_of_set  (m_end_of_set),
        .m_alert_total (m_alert_total)
    );

endmodule
